@@ design/stq_pkg.sv @@
// Package for the sorted timer queue: field widths, the queue entry type
// and the command word that the controller broadcasts to every cell.
// No dependencies.
package stq_pkg;

    localparam int ID_W  = 4;
    localparam int EXP_W = 32;
    localparam int PER_W = 31;

    // One queue position: slot id, expiry tick and repeat period.
    typedef struct packed {
        logic             vld;
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] exp;
        logic [PER_W-1:0] per;
    } t_entry;

    // Operation that all cells carry out in the same cycle.
    typedef enum logic [2:0] {
        CELL_HOLD      = 3'd0,
        CELL_CLEAR     = 3'd1,
        CELL_SCAN_RM   = 3'd2,
        CELL_SCAN_INS  = 3'd3,
        CELL_SHIFT_RM  = 3'd4,
        CELL_SHIFT_INS = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [ID_W-1:0]  key;
        logic [EXP_W-1:0] new_exp;
        logic [PER_W-1:0] new_per;
    } t_cell_cmd;

endpackage

@@ design/stq_req_if.sv @@
// Request channel of the sorted timer queue: valid, ready and the request fields.
// Depends on stq_pkg for the field widths.
interface stq_req_if;
    import stq_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [ID_W-1:0]  timer_id;
    logic [PER_W-1:0] ticks;
    logic             repeat_req;
    logic [EXP_W-1:0] now;

    modport source (output valid, kind, timer_id, ticks, repeat_req, now, input ready);
    modport sink   (input valid, kind, timer_id, ticks, repeat_req, now, output ready);
endinterface

@@ design/stq_rsp_if.sv @@
// Result channel of the sorted timer queue: valid, ready and the head report.
// Depends on stq_pkg for the field widths.
interface stq_rsp_if;
    import stq_pkg::*;

    logic             valid;
    logic             ready;
    logic             alarm_set;
    logic [EXP_W-1:0] alarm_value;
    logic             head_valid;
    logic [ID_W-1:0]  head_id;
    logic [PER_W-1:0] head_period;

    modport source (output valid, alarm_set, alarm_value, head_valid, head_id, head_period,
                    input ready);
    modport sink   (input valid, alarm_set, alarm_value, head_valid, head_id, head_period,
                    output ready);
endinterface

@@ design/sorted_timer_queue_top.sv @@
// Top level of the sorted timer queue: request sequencer, row of queue
// cells and result register. Depends on stq_pkg, stq_req_if, stq_rsp_if, stq_cell.
//
//  channel | direction | transfer moves
//  i_req   | in        | kind, timer_id, ticks, repeat_req, now
//  o_rsp   | out       | alarm_set, alarm_value, head_valid, head_id, head_period
//
// An arm runs the removal sweep and shift, then the insert ones; a disarm only
// the removal; a slot at or above TIMERS goes straight to the result. Each sweep
// walks a flag down the TIMERS cells, one cell per cycle.
// Reset is synchronous, active low, and empties the queue.
// A finished result waits in the output register while the next request is
// taken; the block stalls only when a second result is ready before the first left.
module sorted_timer_queue_top #(
    parameter int TIMERS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stq_req_if.sink   i_req,
    stq_rsp_if.source o_rsp
);
    import stq_pkg::*;

    localparam int CNT_W = $clog2(TIMERS);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_RM_SCAN   = 6'b000010,
        ST_RM_SHIFT  = 6'b000100,
        ST_INS_SCAN  = 6'b001000,
        ST_INS_SHIFT = 6'b010000,
        ST_RESULT    = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             r_kind;
    logic [ID_W-1:0]  r_id;
    logic [EXP_W-1:0] r_new_exp;
    logic [PER_W-1:0] r_new_per;
    logic             r_old_vld;
    logic [ID_W-1:0]  r_old_id;
    logic [EXP_W-1:0] r_old_exp;

    logic             r_out_vld;
    logic             r_alarm_set;
    logic [EXP_W-1:0] r_alarm_value;
    logic             r_head_valid;
    logic [ID_W-1:0]  r_head_id;
    logic [PER_W-1:0] r_head_period;

    t_cell_cmd        w_cmd;
    t_entry           w_entry [TIMERS];
    logic [TIMERS-1:0] w_flag;
    logic [TIMERS-1:0] w_vld;
    logic             w_accept;
    logic             w_in_range;
    logic             w_load;
    logic             w_last;
    t_entry           w_head;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_range = 32'(i_req.timer_id) < TIMERS;
    assign w_last     = r_cnt == CNT_W'(TIMERS - 1);
    assign w_head     = w_entry[0];
    assign w_load     = (r_state == ST_RESULT) && (!r_out_vld || o_rsp.ready);

    assign i_req.ready = r_state == ST_IDLE;

    // Sequencer: clear flags, sweep and shift for removal, then for insert on an arm.
    // The counter stops on the last cell so that the shift sees a full sweep.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '{op: CELL_HOLD, key: r_id, new_exp: r_new_exp, new_per: r_new_per};
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    w_cmd.op = CELL_CLEAR;
                    n_state  = w_in_range ? ST_RM_SCAN : ST_RESULT;
                end
            end
            ST_RM_SCAN: begin
                w_cmd.op = CELL_SCAN_RM;
                n_cnt    = w_last ? r_cnt : r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_RM_SHIFT;
                end
            end
            ST_RM_SHIFT: begin
                w_cmd.op = CELL_SHIFT_RM;
                n_cnt    = '0;
                n_state  = r_kind ? ST_RESULT : ST_INS_SCAN;
            end
            ST_INS_SCAN: begin
                w_cmd.op = CELL_SCAN_INS;
                n_cnt    = w_last ? r_cnt : r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_INS_SHIFT;
                end
            end
            ST_INS_SHIFT: begin
                w_cmd.op = CELL_SHIFT_INS;
                n_cnt    = '0;
                n_state  = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Request capture and a copy of the head as it stood before the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_req.kind;
            r_id      <= i_req.timer_id;
            r_new_exp <= i_req.now + {1'b0, i_req.ticks};
            r_new_per <= i_req.repeat_req ? i_req.ticks : '0;
            r_old_vld <= w_head.vld;
            r_old_id  <= w_head.id;
            r_old_exp <= w_head.exp;
        end
    end

    // Row of cells; the ends see an empty neighbor.
    for (genvar g = 0; g < TIMERS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_flag;

        if (g == 0) begin : g_first
            assign w_left      = '0;
            assign w_left_flag = 1'b0;
        end else begin : g_inner
            assign w_left      = w_entry[g-1];
            assign w_left_flag = w_flag[g-1];
        end
        if (g == TIMERS - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        stq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left      (w_left),
            .i_left_flag (w_left_flag),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_flag      (w_flag[g])
        );
        assign w_vld[g] = w_entry[g].vld;
    end

    // Result register: head report, zeros when the queue is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_alarm_set   <= w_head.vld && (!r_old_vld || (w_head.id != r_old_id) ||
                                            (w_head.exp != r_old_exp));
            r_alarm_value <= w_head.vld ? w_head.exp : '0;
            r_head_valid  <= w_head.vld;
            r_head_id     <= w_head.vld ? w_head.id : '0;
            r_head_period <= w_head.vld ? w_head.per : '0;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.alarm_set   = r_alarm_set;
    assign o_rsp.alarm_value = r_alarm_value;
    assign o_rsp.head_valid  = r_head_valid;
    assign o_rsp.head_id     = r_head_id;
    assign o_rsp.head_period = r_head_period;

    // Occupied cells always form an unbroken run from the head.
    a_vld_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld & (w_vld + TIMERS'(1))) == '0)
        else $error("queue cells are not packed toward the head");

    // A shift only follows a complete sweep of the row.
    a_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RM_SHIFT || r_state == ST_INS_SHIFT) |-> w_last)
        else $error("shift started before the flag reached the last cell");

    // An empty queue reports no alarm and zero fields.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.head_valid) |->
        (!o_rsp.alarm_set && o_rsp.alarm_value == '0 && o_rsp.head_id == '0))
        else $error("empty queue result carries nonzero fields");

    // Every accepted request returns to idle only by loading a result.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && n_state == ST_IDLE) |=> r_out_vld)
        else $error("request finished without a result");

endmodule

@@ design/stq_cell.sv @@
// One position of the sorted timer queue, with its scan flag.
// Depends on stq_pkg; instantiated in a row by sorted_timer_queue_top.
module stq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stq_pkg::t_cell_cmd i_cmd,
    input  stq_pkg::t_entry   i_left,
    input  logic              i_left_flag,
    input  stq_pkg::t_entry   i_right,
    output stq_pkg::t_entry   o_entry,
    output logic              o_flag
);
    import stq_pkg::*;

    logic             r_vld, n_vld;
    logic [ID_W-1:0]  r_id, n_id;
    logic [EXP_W-1:0] r_exp, n_exp;
    logic [PER_W-1:0] r_per, n_per;
    logic             r_flag, n_flag;

    logic [EXP_W-1:0] w_diff;
    logic             w_hit_rm;
    logic             w_hit_ins;
    t_entry           w_next;

    // A removal hits the entry of the named slot. An insert lands at the
    // first entry that is empty or expires strictly later than the new one.
    assign w_diff    = r_exp - i_cmd.new_exp;
    assign w_hit_rm  = r_vld && (r_id == i_cmd.key);
    assign w_hit_ins = !r_vld || ((w_diff != '0) && !w_diff[EXP_W-1]);

    // The flag spreads one position per cycle, so after a full sweep it
    // marks every position at or behind the first hit.
    always_comb begin
        w_next = '{vld: r_vld, id: r_id, exp: r_exp, per: r_per};
        n_flag = r_flag;
        case (i_cmd.op)
            CELL_HOLD: begin
                n_flag = r_flag;
            end
            CELL_CLEAR: begin
                n_flag = 1'b0;
            end
            CELL_SCAN_RM: begin
                n_flag = i_left_flag | w_hit_rm;
            end
            CELL_SCAN_INS: begin
                n_flag = i_left_flag | w_hit_ins;
            end
            CELL_SHIFT_RM: begin
                n_flag = 1'b0;
                if (r_flag) begin
                    w_next = i_right;
                end
            end
            CELL_SHIFT_INS: begin
                n_flag = 1'b0;
                if (r_flag && i_left_flag) begin
                    w_next = i_left;
                end else if (r_flag) begin
                    w_next = '{vld: 1'b1, id: i_cmd.key, exp: i_cmd.new_exp,
                               per: i_cmd.new_per};
                end
            end
            default: begin
                n_flag = r_flag;
            end
        endcase
        n_vld = w_next.vld;
        n_id  = w_next.id;
        n_exp = w_next.exp;
        n_per = w_next.per;
    end

    // Control bits: occupancy and scan flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_flag <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_flag <= n_flag;
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_exp <= n_exp;
        r_per <= n_per;
    end

    assign o_entry = '{vld: r_vld, id: r_id, exp: r_exp, per: r_per};
    assign o_flag  = r_flag;

endmodule
